FILE: rtl/rcq_pkg.sv
// ============================================================================
// rcq_pkg
// Shared types and constants for the reversible circular queue.
// ============================================================================
package rcq_pkg;

    // Default number of ring slots; one slot always stays empty
    localparam int unsigned RCQ_SLOTS = 16;

    // Field widths of the request and result beats
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned COUNT_W = 4;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ = 2'd0,
        REQ_DEQ = 2'd1,
        REQ_REV = 2'd2,
        REQ_NOP = 2'd3
    } t_req;

endpackage

FILE: rtl/reversible_circular_queue_unit.sv
// ============================================================================
// reversible_circular_queue_unit
// Ring-buffer FIFO of signed 32-bit words with an order-reversal request.
// Reverse flips a direction flag; data never moves in the slot memory.
// ============================================================================
// A result beat appears in the cycle after its request is taken.
// Throughput: one request per cycle; busy stays low, the single-port
// slot memory is read or written at most once per request, with a registered read.
// Reset (synchronous, active low) empties the queue and restores normal
// order; the slot memory is not cleared, no entry is read before written.
// The receiver cannot stall: each result is shown for exactly one cycle.
module reversible_circular_queue_unit
    import rcq_pkg::*;
#(
    parameter int unsigned SLOTS = RCQ_SLOTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [REQ_W-1:0]          i_req_type,
    input  logic signed [DATA_W-1:0]  i_enq_value,
    output logic                      o_strobe,
    output logic                      o_accepted,
    output logic signed [DATA_W-1:0]  o_deq_value,
    output logic [COUNT_W-1:0]        o_item_count
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Slot memory and its registered read data
    logic [DATA_W-1:0] r_slot_mem [SLOTS];
    logic [DATA_W-1:0] r_rd_data;

    // Ring pointers and direction
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic             r_rev,  n_rev;

    // Result registers
    logic             r_strobe;
    logic             r_accepted, n_accepted;
    logic             r_deq_ok,   n_deq_ok;
    logic [IDX_W-1:0] r_count,    n_count;

    logic             take;
    t_req             req;
    logic [IDX_W-1:0] head_nxt, head_prv, tail_nxt, tail_prv;
    logic [IDX_W-1:0] held;
    logic             is_full, is_empty;
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [IDX_W+COUNT_W-1:0] count_ext;

    assign busy = 1'b0;
    assign take = start && !busy;
    assign req  = t_req'(i_req_type);

    // Ring step helpers (any slot count, not only powers of two)
    assign head_nxt = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign head_prv = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign tail_nxt = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign tail_prv = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;

    // Held items: (tail - head) mod SLOTS
    assign held = (r_tail >= r_head) ? r_tail - r_head
                                     : IDX_W'(r_tail + SLOTS - r_head);
    assign is_full  = (held == LAST_IDX);
    assign is_empty = (held == '0);

    // Request decode: pointer updates, memory access, result fields
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_rev      = r_rev;
        n_accepted = 1'b0;
        n_deq_ok   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = r_rev ? r_head : tail_nxt;
        mem_raddr  = r_rev ? r_tail : head_nxt;
        if (take) begin
            unique case (req)
                REQ_ENQ: begin
                    if (!is_full) begin
                        mem_we     = 1'b1;
                        n_accepted = 1'b1;
                        if (r_rev) n_head = head_prv;
                        else       n_tail = tail_nxt;
                    end
                end
                REQ_DEQ: begin
                    if (!is_empty) begin
                        mem_re     = 1'b1;
                        n_accepted = 1'b1;
                        n_deq_ok   = 1'b1;
                        if (r_rev) n_tail = tail_prv;
                        else       n_head = head_nxt;
                    end
                end
                REQ_REV: begin
                    n_rev      = !r_rev;
                    n_accepted = 1'b1;
                end
                default: begin
                    // unused code: no change, rejected
                end
            endcase
        end
        // count after this request
        n_count = (n_tail >= n_head) ? n_tail - n_head
                                     : IDX_W'(n_tail + SLOTS - n_head);
    end

    // Slot memory: one write or one read per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[mem_waddr] <= i_enq_value;
        end
        if (mem_re) begin
            r_rd_data <= r_slot_mem[mem_raddr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_rev    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_rev    <= n_rev;
            r_strobe <= take;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_accepted <= n_accepted;
            r_deq_ok   <= n_deq_ok;
            r_count    <= n_count;
        end
    end

    // Output beat; count reported masked to the field width
    assign count_ext    = {{COUNT_W{1'b0}}, r_count};
    assign o_strobe     = r_strobe;
    assign o_accepted   = r_accepted;
    assign o_deq_value  = r_deq_ok ? signed'(r_rd_data) : '0;
    assign o_item_count = count_ext[COUNT_W-1:0];

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_strobe_follows_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_strobe)
        else $error("result beat missing after a taken request");

    a_no_spurious_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> !o_strobe)
        else $error("result beat without a request");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        held <= LAST_IDX)
        else $error("held count exceeds ring capacity");

    a_full_enq_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && req == REQ_ENQ && is_full) |=> ($stable(r_head) && $stable(r_tail)))
        else $error("rejected enqueue moved a pointer");

    a_deq_value_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_accepted) |-> (o_deq_value == '0))
        else $error("rejected request returned data");

endmodule
